// File: src/i2c_master_bit_engine_macros.svh
// ----------------------------------------------------------------------------
// I2C master bit engine assertion macros
// Shorthand for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_BIT_ENGINE_MACROS_SVH
`define I2C_MASTER_BIT_ENGINE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define I2CM_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define I2CM_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/i2cm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bit engine package
// Shared widths, reset values, codes and the classified tick entry.
// ----------------------------------------------------------------------------
package i2cm_pkg;

   localparam int PHASE_W     = 10;
   localparam int TMO_W       = 8;
   localparam int BYTE_W      = 8;
   localparam int OPCODE_W    = 2;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 10;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [PHASE_W-1:0] PHASE_TICKS_RST = 10'd72;
   localparam logic [TMO_W-1:0]   ACK_TIMEOUT_RST = 8'd250;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PHASE_TICKS = 2'd0,
      CSR_ACK_TIMEOUT = 2'd1
   } csr_idx_type;

   typedef enum logic [OPCODE_W-1:0] {
      OP_START = 2'd0,
      OP_STOP  = 2'd1,
      OP_WRITE = 2'd2,
      OP_READ  = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      CMD_NONE  = 3'd0,
      CMD_START = 3'd1,
      CMD_STOP  = 3'd2,
      CMD_WRITE = 3'd3,
      CMD_READ  = 3'd4
   } cmd_type;

   typedef struct packed {
      cmd_type             cmd;
      logic [BYTE_W-1:0]   tx_byte;
      logic                send_ack;
      logic                sda_in;
   } tick_type;

   typedef struct packed {
      logic [PHASE_W-1:0]  phase_ticks;
      logic [TMO_W-1:0]    ack_timeout;
   } cfg_type;

endpackage

// File: src/i2cm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bit engine channels
// Valid/ready channels for ticks, results and register writes.
// ----------------------------------------------------------------------------
interface i2cm_req_if import i2cm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                cmd_valid;
   logic [OPCODE_W-1:0] opcode;
   logic [BYTE_W-1:0]   tx_byte;
   logic                send_ack;
   logic                sda_in;

   modport source (output valid, cmd_valid, opcode, tx_byte, send_ack, sda_in,
                   input ready);
   modport sink   (input valid, cmd_valid, opcode, tx_byte, send_ack, sda_in,
                   output ready);
endinterface

interface i2cm_rsp_if import i2cm_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              scl_drive;
   logic              sda_drive;
   logic              busy_res;
   logic              done_res;
   logic [BYTE_W-1:0] rx_byte;
   logic              ack_missing;

   modport source (output valid, scl_drive, sda_drive, busy_res, done_res, rx_byte,
                   ack_missing, input ready);
   modport sink   (input valid, scl_drive, sda_drive, busy_res, done_res, rx_byte,
                   ack_missing, output ready);
endinterface

interface i2cm_csr_if import i2cm_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: src/i2c_master_bit_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bit engine
// Tick-driven I2C master: start, stop, byte write with ack wait, byte read.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries one beat per bus tick: an optional command plus the
//   sampled SDA level. Commands that arrive while a sequence runs are dropped.
//   rsp_bus returns exactly one beat per request beat, in order: SCL/SDA
//   drive levels, busy, done, last received byte and the missing-ack flag.
//   csr_bus writes phase_ticks (index 0) and ack_timeout (index 1); it is
//   always ready outside reset. Write it only while the engine is idle.
// Timing:
//   A request beat passes through the front register, the two-entry queue
//   and the sequencer's result register, in that order, before its result
//   beat is offered on rsp_bus.
//   One beat per cycle is sustained while rsp_ready stays high; the
//   sequencer step updates its state from its own register.
// Reset:
//   Synchronous reset returns to idle with both lines released and the
//   registers at 72 ticks per phase and an ack timeout of 250; req and csr are not ready.
// Stall:
//   When rsp_ready is low the result holds, the queue fills and req_ready
//   drops once the front register and queue are full; nothing is lost.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine import i2cm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   i2cm_req_if.sink    req_bus,
   i2cm_rsp_if.source  rsp_bus,
   i2cm_csr_if.sink    csr_bus
);

   cfg_type  cfg_ff;
   logic     front_valid;
   logic     front_ready;
   tick_type front_data;
   logic     queue_valid;
   logic     queue_ready;
   tick_type queue_data;

   // Register writes go straight into the configuration register, so never stall them.
   assign csr_bus.ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.phase_ticks <= PHASE_TICKS_RST;
         cfg_ff.ack_timeout <= ACK_TIMEOUT_RST;
      end else if (csr_bus.valid && csr_bus.ready) begin
         case (csr_idx_type'(csr_bus.index))
            CSR_PHASE_TICKS: cfg_ff.phase_ticks <= PHASE_W'(csr_bus.data);
            CSR_ACK_TIMEOUT: cfg_ff.ack_timeout <= csr_bus.data[TMO_W-1:0];
            default: ;
         endcase
      end
   end

   // Classify the command and register the beat.
   i2cm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .tick_valid (front_valid),
      .tick_ready (front_ready),
      .tick_data  (front_data)
   );

   // Decouple the front from the sequencer so each side can stall alone.
   i2cm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_data   (front_data),
      .out_valid (queue_valid),
      .out_ready (queue_ready),
      .out_data  (queue_data)
   );

   // Advance the bus sequence one tick per beat and hold the result.
   i2cm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .tick_valid (queue_valid),
      .tick_ready (queue_ready),
      .tick_data  (queue_data),
      .rsp_bus    (rsp_bus)
   );

endmodule

// File: src/i2cm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master front stage
// Accept tick beats, classify the command and register the entry.
// ----------------------------------------------------------------------------
module i2cm_front import i2cm_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   i2cm_req_if.sink  req_bus,
   output logic      tick_valid,
   input  logic      tick_ready,
   output tick_type  tick_data
);

   logic     valid_ff;
   tick_type tick_ff;
   tick_type tick_in;

   assign req_bus.ready = !reset && (!valid_ff || tick_ready);
   assign tick_valid    = valid_ff;
   assign tick_data     = tick_ff;

   always_comb begin
      tick_in.tx_byte  = req_bus.tx_byte;
      tick_in.send_ack = req_bus.send_ack;
      tick_in.sda_in   = req_bus.sda_in;
      if (!req_bus.cmd_valid) begin
         tick_in.cmd = CMD_NONE;
      end else begin
         case (opcode_type'(req_bus.opcode))
            OP_START: tick_in.cmd = CMD_START;
            OP_STOP:  tick_in.cmd = CMD_STOP;
            OP_WRITE: tick_in.cmd = CMD_WRITE;
            OP_READ:  tick_in.cmd = CMD_READ;
            default:  tick_in.cmd = CMD_NONE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!valid_ff || tick_ready) begin
         valid_ff <= req_bus.valid;
      end
      if (req_bus.valid && req_bus.ready) begin
         tick_ff <= tick_in;
      end
   end

endmodule

// File: src/i2cm_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master tick queue
// Short FIFO that decouples the front stage from the sequencer.
// ----------------------------------------------------------------------------
module i2cm_queue import i2cm_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  tick_type in_data,
   output logic     out_valid,
   input  logic     out_ready,
   output tick_type out_data
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   tick_type         mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             push;
   logic             pop;

   function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] ptr);
      return (ptr == PTR_LAST) ? '0 : ptr + PTR_W'(1);
   endfunction

   assign in_ready  = (count_ff != CNT_FULL);
   assign out_valid = (count_ff != '0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= bump(wr_ptr_ff);
         end
         if (pop) begin
            rd_ptr_ff <= bump(rd_ptr_ff);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

// File: src/i2cm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bus sequencer
// Run one tick per beat through the bus phase sequence; register the result.
// ----------------------------------------------------------------------------
module i2cm_back import i2cm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        tick_valid,
   output logic        tick_ready,
   input  tick_type    tick_data,
   i2cm_rsp_if.source  rsp_bus
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'd0,
      ST_ST0, ST_ST1, ST_ST2, ST_ST3, ST_ST4,
      ST_SP0, ST_SP1, ST_SP2, ST_SP3,
      ST_W0,  ST_W1,  ST_W2,  ST_W3,
      ST_K0,  ST_K1,  ST_K2,  ST_K3,
      ST_R0,  ST_R1,  ST_R2,
      ST_A0,  ST_A1,  ST_A2,  ST_A3
   } step_type;

   typedef struct packed {
      step_type           step;
      logic [PHASE_W-1:0] phase;
      logic [3:0]         bit_cnt;
      logic [BYTE_W-1:0]  shreg;
      logic [TMO_W-1:0]   tmo;
      logic               scl;
      logic               sda;
      logic               ack_choice;
      logic               ack_flag;
      logic [BYTE_W-1:0]  rx_hold;
   } seq_type;

   typedef struct packed {
      logic              scl_drive;
      logic              sda_drive;
      logic              busy_res;
      logic              done_res;
      logic [BYTE_W-1:0] rx_byte;
      logic              ack_missing;
   } rsp_type;

   localparam logic [3:0] BITS_PER_BYTE = 4'd8;

   seq_type            seq_ff;
   seq_type            seq_in;
   rsp_type            out_ff;
   rsp_type            out_in;
   logic               rsp_valid_ff;
   logic               pop;
   logic [PHASE_W-1:0] pt_eff;

   // Enter a phase: reload the phase counter and change at most one line.
   function automatic seq_type enter_step(input seq_type st_i, input step_type s,
                                          input logic [PHASE_W-1:0] pt);
      seq_type st;
      st       = st_i;
      st.step  = s;
      st.phase = pt;
      case (s)
         ST_ST0, ST_ST4, ST_SP0, ST_W0, ST_W3, ST_K3, ST_R1, ST_A0, ST_A3:
            st.scl = 1'b0;
         ST_ST2, ST_SP2, ST_W2, ST_K1, ST_R2, ST_A2:
            st.scl = 1'b1;
         ST_ST1, ST_SP3, ST_K0, ST_R0:
            st.sda = 1'b1;
         ST_ST3, ST_SP1:
            st.sda = 1'b0;
         ST_W1: begin
            st.sda   = st.shreg[BYTE_W-1];
            st.shreg = {st.shreg[BYTE_W-2:0], 1'b0};
         end
         ST_K2:
            st.tmo = '0;
         ST_A1:
            st.sda = !st.ack_choice;
         default:
            st.step = ST_IDLE;
      endcase
      return st;
   endfunction

   assign pt_eff     = (cfg.phase_ticks == '0) ? PHASE_W'(1) : cfg.phase_ticks;
   assign tick_ready = !rsp_valid_ff || rsp_bus.ready;
   assign pop        = tick_valid && tick_ready;

   always_comb begin
      seq_type st;
      logic    done;
      logic    shown_scl;
      logic    shown_sda;
      st   = seq_ff;
      done = 1'b0;

      // Take a command only while idle.
      if (st.step == ST_IDLE && tick_data.cmd != CMD_NONE) begin
         st.bit_cnt = '0;
         case (tick_data.cmd)
            CMD_START: st = enter_step(st, ST_ST0, pt_eff);
            CMD_STOP:  st = enter_step(st, ST_SP0, pt_eff);
            CMD_WRITE: begin
               st.shreg = tick_data.tx_byte;
               st       = enter_step(st, ST_W0, pt_eff);
            end
            CMD_READ: begin
               st.shreg      = '0;
               st.ack_choice = tick_data.send_ack;
               st            = enter_step(st, ST_R0, pt_eff);
            end
            default: ;
         endcase
      end

      shown_scl = st.scl;
      shown_sda = st.sda;

      if (st.step == ST_K2) begin
         // Poll the acknowledge once per tick.
         if (!tick_data.sda_in) begin
            st = enter_step(st, ST_K3, pt_eff);
         end else if (st.tmo >= cfg.ack_timeout) begin
            st.ack_flag = 1'b1;
            st          = enter_step(st, ST_SP0, pt_eff);
         end else begin
            st.tmo = st.tmo + TMO_W'(1);
         end
      end else if (st.step != ST_IDLE) begin
         if (st.phase != '0) begin
            st.phase = st.phase - PHASE_W'(1);
         end
         if (st.phase == '0) begin
            case (st.step)
               ST_ST4, ST_SP3: begin
                  st.step = ST_IDLE;
                  done    = 1'b1;
               end
               ST_K3: begin
                  st.ack_flag = 1'b0;
                  st.step     = ST_IDLE;
                  done        = 1'b1;
               end
               ST_A3: begin
                  st.rx_hold = st.shreg;
                  st.step    = ST_IDLE;
                  done       = 1'b1;
               end
               ST_W3: begin
                  st.bit_cnt = st.bit_cnt + 4'd1;
                  st = enter_step(st, (st.bit_cnt < BITS_PER_BYTE) ? ST_W1 : ST_K0, pt_eff);
               end
               ST_R2: begin
                  st.shreg   = {st.shreg[BYTE_W-2:0], tick_data.sda_in};
                  st.bit_cnt = st.bit_cnt + 4'd1;
                  st = enter_step(st, (st.bit_cnt < BITS_PER_BYTE) ? ST_R1 : ST_A0, pt_eff);
               end
               default:
                  st = enter_step(st, step_type'(5'(st.step) + 5'd1), pt_eff);
            endcase
         end
      end

      seq_in             = st;
      out_in.scl_drive   = shown_scl;
      out_in.sda_drive   = shown_sda;
      out_in.busy_res    = (st.step != ST_IDLE);
      out_in.done_res    = done;
      out_in.rx_byte     = st.rx_hold;
      out_in.ack_missing = st.ack_flag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff.step       <= ST_IDLE;
         seq_ff.phase      <= '0;
         seq_ff.bit_cnt    <= '0;
         seq_ff.shreg      <= '0;
         seq_ff.tmo        <= '0;
         seq_ff.scl        <= 1'b1;
         seq_ff.sda        <= 1'b1;
         seq_ff.ack_choice <= 1'b0;
         seq_ff.ack_flag   <= 1'b0;
         seq_ff.rx_hold    <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         if (pop) begin
            seq_ff <= seq_in;
         end
         if (tick_ready) begin
            rsp_valid_ff <= tick_valid;
         end
      end
      if (pop) begin
         out_ff <= out_in;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.scl_drive   = out_ff.scl_drive;
   assign rsp_bus.sda_drive   = out_ff.sda_drive;
   assign rsp_bus.busy_res    = out_ff.busy_res;
   assign rsp_bus.done_res    = out_ff.done_res;
   assign rsp_bus.rx_byte     = out_ff.rx_byte;
   assign rsp_bus.ack_missing = out_ff.ack_missing;

endmodule

// File: src/i2cm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bit engine checker
// Port-level assertions on beat ordering and result consistency.
// ----------------------------------------------------------------------------
`include "i2c_master_bit_engine_macros.svh"

module i2cm_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_busy,
   input logic rsp_done
);

   localparam logic [2:0] PEND_MAX = 3'd4;

   logic [2:0] pend_ff;
   logic [2:0] pend_in;
   logic       req_beat;
   logic       rsp_beat;

   assign req_beat = req_valid && req_ready;
   assign rsp_beat = rsp_valid && rsp_ready;

   always_comb begin
      pend_in = pend_ff;
      if (req_beat && !rsp_beat) begin
         pend_in = pend_ff + 3'd1;
      end else if (rsp_beat && !req_beat) begin
         pend_in = pend_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   `I2CM_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "result beat dropped while stalled")
   `I2CM_ASSERT_IMP(a_rsp_has_req, clock, reset, rsp_beat, pend_ff != 3'd0, "result beat without request beat")
   `I2CM_ASSERT_IMP(a_pend_bound, clock, reset, 1'b1, pend_ff <= PEND_MAX, "too many beats in flight")
   `I2CM_ASSERT_IMP(a_done_idle, clock, reset, rsp_valid && rsp_done, !rsp_busy, "done while still busy")

endmodule

bind i2c_master_bit_engine i2cm_checker u_i2cm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_busy  (rsp_bus.busy_res),
   .rsp_done  (rsp_bus.done_res)
);
